// ----- rtl/core/stt_pkg.sv -----
// Shared types and codes for the software timer table.
// Used by stt_cell and software_timer_table; depends on nothing else.
`default_nettype none

package stt_pkg;

    // Operation codes carried in the command transfer
    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_PAUSE = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // Channel modes
    localparam logic [2:0] MODE_UNINIT   = 3'd0;
    localparam logic [2:0] MODE_STOPPED  = 3'd1;
    localparam logic [2:0] MODE_RUNNING  = 3'd2;
    localparam logic [2:0] MODE_PAUSED   = 3'd3;
    localparam logic [2:0] MODE_FINISHED = 3'd4;

    // Loop limit that repeats for ever
    localparam logic [31:0] LIMIT_FOREVER = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]         operation;
        logic [3:0]         channel;
        logic [31:0]        period_ms;
        logic signed [31:0] loop_limit;
        logic [31:0]        now_ms;
    } cmd_t;

    typedef struct packed {
        logic [3:0] fired_channel;
        logic       finished;
        logic       last;
    } evt_t;

    // Write broadcast to every cell for init, start, pause and stop
    typedef struct packed {
        logic        valid;
        logic [2:0]  op;
        logic [3:0]  channel;
        logic [31:0] period;
        logic [31:0] limit;
        logic [31:0] now;
    } wr_t;

    // Status of the cell that holds the sweep token
    typedef struct packed {
        logic fire;
        logic fin;
    } hit_t;

endpackage

`default_nettype wire

// ----- rtl/core/stt_cell.sv -----
// One timer channel of the chain: its state, its expiry check and one token stage.
// Depends on stt_pkg.
`default_nettype none

module stt_cell #(
    parameter int unsigned INDEX = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire stt_pkg::wr_t   wr,
    input  wire logic           adv,
    input  wire logic           tok_in,
    input  wire logic [31:0]    now_in,
    output logic                tok_out,
    output logic [31:0]         now_out,
    output stt_pkg::hit_t       hit
);

    logic [2:0]  mode_reg,   mode_next;
    logic [31:0] period_reg, period_next;
    logic [31:0] limit_reg,  limit_next;
    logic [31:0] start_reg,  start_next;
    logic [31:0] pause_reg,  pause_next;
    logic [31:0] loops_reg,  loops_next;
    logic        tok_reg;
    logic [31:0] now_fwd_reg;

    logic        sel;
    logic [31:0] expiry;
    logic [31:0] loops_inc;
    logic        counted;
    logic        fire;
    logic        fin;

    assign sel       = wr.valid && (32'(wr.channel) == 32'(INDEX));
    assign expiry    = start_reg + period_reg;
    assign loops_inc = loops_reg + 32'd1;
    assign counted   = (limit_reg != stt_pkg::LIMIT_FOREVER);
    assign fire      = (mode_reg == stt_pkg::MODE_RUNNING) && (now_in > expiry);
    assign fin       = counted && (loops_inc == limit_reg);

    assign hit.fire = tok_in && fire;
    assign hit.fin  = tok_in && fire && fin;
    assign tok_out  = tok_reg;
    assign now_out  = now_fwd_reg;

    always_comb
    begin
        mode_next   = mode_reg;
        period_next = period_reg;
        limit_next  = limit_reg;
        start_next  = start_reg;
        pause_next  = pause_reg;
        loops_next  = loops_reg;
        if (sel)
        begin
            unique case (wr.op)
                stt_pkg::OP_INIT:
                begin
                    period_next = wr.period;
                    limit_next  = wr.limit;
                end
                stt_pkg::OP_START:
                begin
                    // resume keeps the elapsed span, anything else restarts
                    if (mode_reg == stt_pkg::MODE_PAUSED)
                    begin
                        start_next = wr.now - (pause_reg - start_reg);
                    end
                    else
                    begin
                        start_next = wr.now;
                        loops_next = '0;
                    end
                    mode_next = stt_pkg::MODE_RUNNING;
                end
                stt_pkg::OP_PAUSE:
                begin
                    if (mode_reg == stt_pkg::MODE_RUNNING)
                    begin
                        pause_next = wr.now;
                        mode_next  = stt_pkg::MODE_PAUSED;
                    end
                end
                stt_pkg::OP_STOP:
                begin
                    if (mode_reg != stt_pkg::MODE_UNINIT)
                    begin
                        mode_next = stt_pkg::MODE_STOPPED;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (tok_in && adv && fire)
        begin
            start_next = now_in;
            if (counted)
            begin
                loops_next = loops_inc;
                if (fin)
                begin
                    mode_next = stt_pkg::MODE_FINISHED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stt_pkg::MODE_UNINIT;
            period_reg <= '0;
            limit_reg  <= '0;
            start_reg  <= '0;
            pause_reg  <= '0;
            loops_reg  <= '0;
            tok_reg    <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            period_reg <= period_next;
            limit_reg  <= limit_next;
            start_reg  <= start_next;
            pause_reg  <= pause_next;
            loops_reg  <= loops_next;
            // hand the token on only when the sweep may advance
            if (adv)
            begin
                tok_reg <= tok_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            now_fwd_reg <= now_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/software_timer_table.sv -----
// Top level of the software timer table: command decode, sweep control and result queue
// around a chain of stt_cell instances. Depends on stt_pkg and stt_cell.
//
//  channel  | valid     | stall     | payload          | direction
//  ---------+-----------+-----------+------------------+----------
//  command  | cmd_valid | cmd_stall | cmd (cmd_t)      | in
//  event    | evt_valid | evt_stall | evt (evt_t)      | out
//
// A tick walks a token down the chain, one channel per cycle, except that the token
// is held while a further trigger is found and a held trigger has nowhere to go
// because the event side stalls. cmd_stall stays high for the whole sweep. One
// trigger is held back until the next one or the end of the sweep so that the final
// event carries last.
// Reset clears every channel to uninitialised with all counters at zero.
`default_nettype none

module software_timer_table #(
    parameter int unsigned NUM_TIMERS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire stt_pkg::cmd_t cmd,
    output logic               evt_valid,
    input  wire logic          evt_stall,
    output stt_pkg::evt_t      evt
);

    localparam int unsigned CW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  cnt_reg,   cnt_next;
    logic           tok0_reg,  tok0_next;
    logic [31:0]    now_reg;
    logic           pend_valid_reg, pend_valid_next;
    logic [3:0]     pend_ch_reg,    pend_ch_next;
    logic           pend_fin_reg,   pend_fin_next;
    logic           out_valid_reg,  out_valid_next;
    stt_pkg::evt_t  out_reg,        out_next;

    logic           cmd_take;
    logic           tick_take;
    logic           out_busy;
    logic           adv;
    logic           fire_any;
    logic           fin_any;
    stt_pkg::wr_t   wr;

    logic           tok_chain [0:NUM_TIMERS];
    logic [31:0]    now_chain [0:NUM_TIMERS];
    stt_pkg::hit_t  hits      [0:NUM_TIMERS-1];

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign tick_take = cmd_take && (cmd.operation == stt_pkg::OP_TICK);
    assign out_busy  = out_valid_reg && evt_stall;
    // hold the token while a second trigger has nowhere to go
    assign adv       = !(fire_any && pend_valid_reg && out_busy);

    assign wr.valid  = cmd_take && (cmd.operation != stt_pkg::OP_TICK);
    assign wr.op     = cmd.operation;
    assign wr.channel = cmd.channel;
    assign wr.period = cmd.period_ms;
    assign wr.limit  = cmd.loop_limit;
    assign wr.now    = cmd.now_ms;

    assign tok_chain[0] = tok0_reg;
    assign now_chain[0] = now_reg;

    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_cell
        stt_cell #(
            .INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .adv     (adv),
            .tok_in  (tok_chain[g]),
            .now_in  (now_chain[g]),
            .tok_out (tok_chain[g+1]),
            .now_out (now_chain[g+1]),
            .hit     (hits[g])
        );
    end

    always_comb
    begin
        fire_any = 1'b0;
        fin_any  = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            fire_any = fire_any | hits[i].fire;
            fin_any  = fin_any  | hits[i].fin;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        tok0_next       = tok0_reg;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        pend_fin_next   = pend_fin_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && evt_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_take)
                begin
                    tok0_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (adv)
                begin
                    tok0_next = 1'b0;
                    cnt_next  = cnt_reg + CW'(1);
                    if (fire_any)
                    begin
                        // release the held trigger, it is not the final one
                        if (pend_valid_reg)
                        begin
                            out_next.fired_channel = pend_ch_reg;
                            out_next.finished      = pend_fin_reg;
                            out_next.last          = 1'b0;
                            out_valid_next         = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_ch_next    = 4'(cnt_reg);
                        pend_fin_next   = fin_any;
                    end
                end
                if (tok_chain[NUM_TIMERS])
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_busy)
                begin
                    out_next.fired_channel = pend_ch_reg;
                    out_next.finished      = pend_fin_reg;
                    out_next.last          = 1'b1;
                    out_valid_next         = 1'b1;
                    pend_valid_next        = 1'b0;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            tok0_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            tok0_reg       <= tok0_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            now_reg <= cmd.now_ms;
        end
        pend_ch_reg  <= pend_ch_next;
        pend_fin_reg <= pend_fin_next;
        out_reg      <= out_next;
    end

    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

endmodule

`default_nettype wire

// ----- tb/tb_software_timer_table.sv -----
// Self-checking testbench for software_timer_table: directed table, then random commands.
// Depends on stt_pkg and the software_timer_table RTL; needs no other file.
`timescale 1ns / 1ps

module tb_software_timer_table;

    localparam int TIMERS       = 16;
    localparam int RANDOM_ITEMS = 204;
    localparam int CALM_ITEMS   = 30;
    localparam int LONG_HOLD    = 250;
    localparam int HOLD_AT_ITEM = 60;

    // Operation codes the block must ignore
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam logic          BY_HAND      = 1'b1;
    localparam logic          BY_PREDICTOR = 1'b0;
    localparam stt_pkg::evt_t NO_EVT       = '0;

    typedef struct packed {
        stt_pkg::cmd_t cmd;
        logic          by_hand;
        logic          one_evt;
        stt_pkg::evt_t evt;
    } stim_row_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cmd_valid;
    logic          cmd_stall;
    stt_pkg::cmd_t cmd;
    logic          evt_valid;
    logic          evt_stall;
    stt_pkg::evt_t evt;

    // Predicted channel state
    logic [2:0]  chan_mode   [TIMERS];
    logic [31:0] chan_period [TIMERS];
    logic [31:0] chan_limit  [TIMERS];
    logic [31:0] chan_start  [TIMERS];
    logic [31:0] chan_pause  [TIMERS];
    logic [31:0] chan_loops  [TIMERS];

    stt_pkg::evt_t fired_now[$];
    stt_pkg::evt_t events_due[$];
    stim_row_t     directed_rows[$];

    int  fail_count       = 0;
    int  events_checked   = 0;
    int  events_predicted = 0;
    int  commands_sent    = 0;
    int  ticks_sent       = 0;
    bit  calm             = 1'b0;
    bit  hold_request     = 1'b0;

    software_timer_table #(
        .NUM_TIMERS (TIMERS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one command to the predicted table; triggers of a tick land in fired_now.
    function automatic void apply_command(input stt_pkg::cmd_t c);
        int            i;
        logic [31:0]   deadline;
        logic          fin;
        stt_pkg::evt_t e;
        fired_now = {};
        case (c.operation)
            stt_pkg::OP_TICK:
            begin
                for (i = 0; i < TIMERS; i++)
                begin
                    deadline = chan_start[i] + chan_period[i];
                    if (chan_mode[i] == stt_pkg::MODE_RUNNING && c.now_ms > deadline)
                    begin
                        fin = 1'b0;
                        chan_start[i] = c.now_ms;
                        if (chan_limit[i] != stt_pkg::LIMIT_FOREVER)
                        begin
                            chan_loops[i] = chan_loops[i] + 32'd1;
                            if (chan_loops[i] == chan_limit[i])
                            begin
                                chan_mode[i] = stt_pkg::MODE_FINISHED;
                                fin = 1'b1;
                            end
                        end
                        e.fired_channel = i[3:0];
                        e.finished      = fin;
                        e.last          = 1'b0;
                        fired_now.insert(fired_now.size(), e);
                    end
                end
                if (fired_now.size() != 0)
                    fired_now[fired_now.size() - 1].last = 1'b1;
            end
            stt_pkg::OP_INIT:
            begin
                chan_period[c.channel] = c.period_ms;
                chan_limit[c.channel]  = c.loop_limit;
            end
            stt_pkg::OP_START:
            begin
                // resume keeps the elapsed part of the run
                if (chan_mode[c.channel] == stt_pkg::MODE_PAUSED)
                    chan_start[c.channel] = c.now_ms -
                        (chan_pause[c.channel] - chan_start[c.channel]);
                else
                begin
                    chan_start[c.channel] = c.now_ms;
                    chan_loops[c.channel] = 32'd0;
                end
                chan_mode[c.channel] = stt_pkg::MODE_RUNNING;
            end
            stt_pkg::OP_PAUSE:
            begin
                if (chan_mode[c.channel] == stt_pkg::MODE_RUNNING)
                begin
                    chan_pause[c.channel] = c.now_ms;
                    chan_mode[c.channel]  = stt_pkg::MODE_PAUSED;
                end
            end
            stt_pkg::OP_STOP:
            begin
                if (chan_mode[c.channel] != stt_pkg::MODE_UNINIT)
                    chan_mode[c.channel] = stt_pkg::MODE_STOPPED;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_row(input logic [2:0] op, input logic [3:0] ch,
                                    input logic [31:0] per, input logic [31:0] lim,
                                    input logic [31:0] now, input logic by_hand,
                                    input logic one_evt, input stt_pkg::evt_t ev);
        stim_row_t r;
        r.cmd.operation  = op;
        r.cmd.channel    = ch;
        r.cmd.period_ms  = per;
        r.cmd.loop_limit = lim;
        r.cmd.now_ms     = now;
        r.by_hand        = by_hand;
        r.one_evt        = one_evt;
        r.evt            = ev;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Offer one command, hold it until the transfer, then record what it should cause.
    task automatic send_cmd(input stt_pkg::cmd_t c, input logic by_hand, input logic one_evt,
                            input stt_pkg::evt_t ev);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        apply_command(c);
        if (by_hand)
        begin
            if (one_evt)
            begin
                events_due.insert(events_due.size(), ev);
                events_predicted++;
            end
        end
        else
        begin
            foreach (fired_now[k])
                events_due.insert(events_due.size(), fired_now[k]);
            events_predicted += fired_now.size();
        end
        commands_sent++;
        if (c.operation == stt_pkg::OP_TICK)
            ticks_sent++;
    endtask

    // Event side: short random stalls, plus one long hold-off on request
    initial
    begin
        evt_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                evt_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                evt_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                evt_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                evt_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : event_check
        stt_pkg::evt_t due;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (events_due.size() == 0)
            begin
                $display("%0t: unexpected event, expected none, got ch %0d fin %0b last %0b",
                         $time, evt.fired_channel, evt.finished, evt.last);
                fail_count++;
            end
            else
            begin
                due = events_due.pop_front();
                if (evt.fired_channel !== due.fired_channel)
                begin
                    $display("%0t: fired_channel expected %0d, got %0d",
                             $time, due.fired_channel, evt.fired_channel);
                    fail_count++;
                end
                if (evt.finished !== due.finished)
                begin
                    $display("%0t: finished expected %0b, got %0b",
                             $time, due.finished, evt.finished);
                    fail_count++;
                end
                if (evt.last !== due.last)
                begin
                    $display("%0t: last expected %0b, got %0b", $time, due.last, evt.last);
                    fail_count++;
                end
                events_checked++;
            end
        end
    end

    initial
    begin : stimulus
        stt_pkg::cmd_t c;
        int            n;
        int            pick;
        logic [31:0]   clock_ms;

        rst_n = 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        foreach (chan_mode[i])
        begin
            chan_mode[i]   = stt_pkg::MODE_UNINIT;
            chan_period[i] = '0;
            chan_limit[i]  = '0;
            chan_start[i]  = '0;
            chan_pause[i]  = '0;
            chan_loops[i]  = '0;
        end

        // Tick after reset, init alone, stop and pause on an idle channel
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0,  32'd0, 32'hFFFF_FFFF,
                BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_INIT,  4'd0,  32'd10, 32'd2, 32'd0,   BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0,  32'd0, 32'd100, BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_STOP,  4'd1,  32'd0,  32'd0, 32'd0,   BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_PAUSE, 4'd0,  32'd0,  32'd0, 32'd50,  BY_HAND, 1'b0, NO_EVT);
        // Equal time does not fire; the second trigger reaches the limit
        add_row(stt_pkg::OP_START, 4'd0,  32'd0,  32'd0, 32'd100, BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0,  32'd0, 32'd110, BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0,  32'd0, 32'd111, BY_HAND, 1'b1,
                '{4'd0, 1'b0, 1'b1});
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0,  32'd0, 32'd122, BY_HAND, 1'b1,
                '{4'd0, 1'b1, 1'b1});
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0,  32'd0, 32'd200, BY_HAND, 1'b0, NO_EVT);
        // Forever channel whose deadline wraps past zero
        add_row(stt_pkg::OP_INIT,  4'd15, 32'd5, stt_pkg::LIMIT_FOREVER, 32'd0,
                BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_START, 4'd15, 32'd0, 32'd0, 32'hFFFF_FFFE, BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0, 32'd0, 32'd4,  BY_HAND, 1'b1,
                '{4'd15, 1'b0, 1'b1});
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0, 32'd0, 32'd10, BY_HAND, 1'b1,
                '{4'd15, 1'b0, 1'b1});
        // Largest period, zero limit, most negative limit, period zero
        add_row(stt_pkg::OP_INIT,  4'd7,  32'hFFFF_FFFF, 32'd0, 32'd0, BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_START, 4'd7,  32'd0, 32'd0, 32'd0,  BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_INIT,  4'd3,  32'd0, 32'h8000_0000, 32'd0, BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_START, 4'd3,  32'd0, 32'd0, 32'd20, BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0, 32'd0, 32'hFFFF_FFFF,
                BY_PREDICTOR, 1'b0, NO_EVT);
        // Pause and resume across the wrap of the clock
        add_row(stt_pkg::OP_PAUSE, 4'd3,  32'd0, 32'd0, 32'd5,  BY_PREDICTOR, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_START, 4'd3,  32'd0, 32'd0, 32'd40, BY_PREDICTOR, 1'b0, NO_EVT);
        // Unused codes carry no effect
        add_row(OP_RSVD5, 4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                BY_HAND, 1'b0, NO_EVT);
        add_row(OP_RSVD6, 4'd0,  32'd0, 32'd0, 32'd0, BY_HAND, 1'b0, NO_EVT);
        add_row(OP_RSVD7, 4'd9,  32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
                BY_HAND, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_STOP,  4'd15, 32'd0, 32'd0, 32'd0,   BY_PREDICTOR, 1'b0, NO_EVT);
        add_row(stt_pkg::OP_TICK,  4'd0,  32'd0, 32'd0, 32'd100, BY_PREDICTOR, 1'b0, NO_EVT);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_cmd(directed_rows[k].cmd, directed_rows[k].by_hand,
                     directed_rows[k].one_evt, directed_rows[k].evt);

        // Start near the top so the time base wraps early on
        clock_ms = 32'hFFFF_FF80;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n == HOLD_AT_ITEM)
                hold_request = 1'b1;
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            c.channel    = 4'($urandom_range(0, TIMERS - 1));
            c.period_ms  = $urandom;
            c.loop_limit = $urandom;
            c.now_ms     = clock_ms;
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                clock_ms    = clock_ms + $urandom_range(0, 12);
                c.now_ms    = clock_ms;
                c.operation = stt_pkg::OP_TICK;
            end
            else if (pick < 55)
            begin
                c.operation = stt_pkg::OP_INIT;
                if ($urandom_range(0, 7) != 0)
                    c.period_ms = $urandom_range(0, 25);
                case ($urandom_range(0, 3)) inside
                    0:       c.loop_limit = stt_pkg::LIMIT_FOREVER;
                    1, 2:    c.loop_limit = $urandom_range(1, 4);
                    default: c.loop_limit = $urandom;
                endcase
                c.now_ms = $urandom;
            end
            else if (pick < 73)
                c.operation = stt_pkg::OP_START;
            else if (pick < 83)
                c.operation = stt_pkg::OP_PAUSE;
            else if (pick < 92)
            begin
                c.operation = stt_pkg::OP_STOP;
                c.now_ms    = $urandom;
            end
            else
            begin
                // noise: any code, any time
                c.operation = 3'($urandom_range(0, 7));
                c.now_ms    = $urandom;
            end
            send_cmd(c, BY_PREDICTOR, 1'b0, NO_EVT);
            n++;
        end
        cmd_valid <= 1'b0;

        while (events_due.size() != 0)
            @(posedge clk);
        repeat (TIMERS + 8) @(posedge clk);

        $display("summary: %0d commands (%0d ticks, %0d directed), %0d of %0d events checked",
                 commands_sent, ticks_sent, directed_rows.size(), events_checked,
                 events_predicted);
        $display("summary: %0d mismatches, one long event hold-off of %0d cycles",
                 fail_count, LONG_HOLD);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d events outstanding", events_due.size());
        $display("tb: failure");
        $finish;
    end

endmodule
